### hdl/lsps_pkg.sv
// Shared types, register codes and helpers of the line sensor steering block.
package lsps_pkg;

  localparam int unsigned SensW    = 8;
  localparam int unsigned GainW    = 16;
  localparam int unsigned LimW     = 7;
  localparam int unsigned DbW      = 6;
  localparam int unsigned DevW     = 7;
  localparam int unsigned IntegW   = 16;
  localparam int unsigned ProdW    = 24;
  localparam int unsigned MulAccW  = ProdW - 1;
  localparam int unsigned SteerW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_ILIM,
    REG_OLIM,
    REG_MIN_DRIVE,
    REG_DEADBAND
  } cfg_reg_e;

  // Centroid unit sequencer
  typedef enum logic [1:0] {
    CEN_IDLE,
    CEN_SCAN,
    CEN_DIV
  } cen_state_e;

  // Top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTROID,
    ST_MUL_I,
    ST_INT_CLAMP,
    ST_MUL_P,
    ST_MUL_D,
    ST_OUT_CLAMP,
    ST_FINISH
  } ctl_state_e;

  // Centroid result handed to the controller
  typedef struct packed {
    logic signed [DevW-1:0] dev;
    logic                   lost;
  } cen_res_t;

  // Weight of one sensor position, leftmost first
  function automatic logic signed [DevW-1:0] sensor_weight(input logic [2:0] idx);
    logic signed [DevW-1:0] w;
    case (idx)
      3'd0:    w = -7'sd35;
      3'd1:    w = -7'sd25;
      3'd2:    w = -7'sd15;
      3'd3:    w = -7'sd5;
      3'd4:    w = 7'sd5;
      3'd5:    w = 7'sd15;
      3'd6:    w = 7'sd25;
      3'd7:    w = 7'sd35;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Saturate a Q.8 value to +-lim whole units
  function automatic logic signed [ProdW-1:0] clamp_sym(input logic signed [ProdW-1:0] v,
                                                        input logic [LimW-1:0] lim);
    logic signed [ProdW-1:0] bound;
    logic signed [ProdW-1:0] r;
    bound = $signed({{(ProdW-LimW-8){1'b0}}, lim, 8'b0});
    if (v > bound) begin
      r = bound;
    end else if (v < -bound) begin
      r = -bound;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/lsps_centroid.sv
// Bit-serial weighted centroid: scans the sensor word, then divides sum by count unless the line is lost.
module lsps_centroid (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [lsps_pkg::SensW-1:0]          sensors_i,
  input  logic signed [lsps_pkg::DevW-1:0]    prev_dev_i,
  output logic                                done_o,
  output lsps_pkg::cen_res_t                  res_o
);

  lsps_pkg::cen_state_e state_q, state_d;
  logic [lsps_pkg::SensW-1:0] sens_q, sens_d;
  logic [2:0]                 idx_q, idx_d;
  logic signed [8:0]          sum_q, sum_d;
  logic [3:0]                 cnt_q, cnt_d;
  logic [7:0]                 dvd_q, dvd_d;
  logic [2:0]                 rem_q, rem_d;
  logic                       neg_q, neg_d;
  logic                       done_q, done_d;
  lsps_pkg::cen_res_t         res_q, res_d;

  logic signed [8:0] sum_nx;
  logic [3:0]        cnt_nx;
  logic [8:0]        sum_mag;
  logic [3:0]        rem_sh;
  logic [3:0]        divisor;
  logic              ge;
  logic [7:0]        quot;

  // Hold state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsps_pkg::CEN_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    sens_q <= sens_d;
    idx_q  <= idx_d;
    sum_q  <= sum_d;
    cnt_q  <= cnt_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  // Accumulate one sensor bit and take one quotient bit per cycle
  always_comb begin
    state_d = state_q;
    sens_d  = sens_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    res_d   = res_q;

    sum_nx  = sens_q[0] ? sum_q + 9'(lsps_pkg::sensor_weight(idx_q)) : sum_q;
    cnt_nx  = sens_q[0] ? cnt_q + 4'd1 : cnt_q;
    sum_mag = sum_nx[8] ? 9'(-sum_nx) : 9'(sum_nx);

    divisor = {1'b0, cnt_q[2:0]};
    rem_sh  = {rem_q, dvd_q[7]};
    ge      = (rem_sh >= divisor);
    quot    = {dvd_q[6:0], ge};

    case (state_q)
      lsps_pkg::CEN_IDLE: begin
        if (start_i) begin
          sens_d  = sensors_i;
          idx_d   = '0;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = lsps_pkg::CEN_SCAN;
        end
      end
      lsps_pkg::CEN_SCAN: begin
        sum_d  = sum_nx;
        cnt_d  = cnt_nx;
        sens_d = sens_q >> 1;
        idx_d  = idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          if (cnt_nx == 4'd0 || cnt_nx == 4'd8) begin
            // line lost: hold the last deviation
            res_d.dev  = prev_dev_i;
            res_d.lost = 1'b1;
            done_d     = 1'b1;
            state_d    = lsps_pkg::CEN_IDLE;
          end else begin
            dvd_d   = sum_mag[7:0];
            neg_d   = sum_nx[8];
            rem_d   = '0;
            state_d = lsps_pkg::CEN_DIV;
          end
        end
      end
      lsps_pkg::CEN_DIV: begin
        rem_d = ge ? 3'(rem_sh - divisor) : rem_sh[2:0];
        dvd_d = quot;
        idx_d = idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          // quotient magnitude stays below 64; apply sign for truncation toward zero
          res_d.dev  = neg_q ? -$signed({1'b0, quot[5:0]}) : $signed({1'b0, quot[5:0]});
          res_d.lost = 1'b0;
          done_d     = 1'b1;
          state_d    = lsps_pkg::CEN_IDLE;
        end
      end
      default: state_d = lsps_pkg::CEN_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/lsps_mul.sv
// Shift-add multiplier: unsigned gain times signed 8-bit factor, one factor bit per cycle.
module lsps_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [lsps_pkg::GainW-1:0]           gain_i,
  input  logic signed [7:0]                    mplier_i,
  output logic                                 done_o,
  output logic signed [lsps_pkg::ProdW-1:0]    prod_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [2:0]                    cnt_q, cnt_d;
  logic [lsps_pkg::MulAccW-1:0]  mcand_q, mcand_d;
  logic [lsps_pkg::MulAccW-1:0]  acc_q, acc_d;
  logic [6:0]                    mplier_q, mplier_d;
  logic                          neg_q, neg_d;
  logic [7:0]                    mag8;

  // Hold control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    mplier_q <= mplier_d;
    neg_q    <= neg_d;
  end

  // Load operands, then add the shifted gain for each set factor bit
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    mplier_d = mplier_q;
    neg_d    = neg_q;
    mag8     = mplier_i[7] ? 8'(-mplier_i) : 8'(mplier_i);

    if (!busy_q) begin
      if (start_i) begin
        mcand_d  = lsps_pkg::MulAccW'(gain_i);
        mplier_d = mag8[6:0];
        acc_d    = '0;
        neg_d    = mplier_i[7];
        cnt_d    = '0;
        busy_d   = 1'b1;
      end
    end else begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 3'd1;
      if (cnt_q == 3'd6) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

endmodule

### hdl/line_sensor_pid_steering_top.sv
// Top level of the line sensor steering block: centroid, PID sequencing and output register.
//
//  channel   | direction | payload
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tdata[7:0] sensors
//  m_axis    | out       | tdata[7:0] steer, [14:8] deviation; tuser line_lost
//  cfg       | in        | cfg_we_i, cfg_idx_i register index, cfg_wdata_i
//
// Each accepted word goes through the sensor scan and the bit-serial division in
// the centroid unit (the division is skipped when the line is lost), then through
// three passes of the shared shift-add multiplier for the I, P and D products.
// Reset restores the register defaults and clears the previous deviation and integral.
// A finished word waits in the output register; a new word is taken meanwhile and
// its result is held back only until the output register is free.
module line_sensor_pid_steering_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sensor words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] sensors
  // steering words
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata,   // [7:0] steer, [14:8] deviation
  output logic                                m_axis_tuser,   // [0] line_lost
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [lsps_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [lsps_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  // Configuration registers
  logic [lsps_pkg::GainW-1:0] kp_q, ki_q, kd_q;
  logic [lsps_pkg::LimW-1:0]  ilim_q, olim_q, md_q;
  logic [lsps_pkg::DbW-1:0]   db_q;

  lsps_pkg::ctl_state_e state_q, state_d;
  logic signed [lsps_pkg::DevW-1:0]   dev_q, dev_d;
  logic                               lost_q, lost_d;
  logic                               in_band_q, in_band_d;
  logic signed [lsps_pkg::DevW-1:0]   prev_q, prev_d;
  logic signed [lsps_pkg::IntegW-1:0] integ_q, integ_d;
  logic signed [lsps_pkg::ProdW-1:0]  sum_q, sum_d;
  logic                               out_valid_q, out_valid_d;
  logic [lsps_pkg::SteerW-1:0]        steer_q, steer_d;
  logic [lsps_pkg::DevW-1:0]          out_dev_q, out_dev_d;
  logic                               out_lost_q, out_lost_d;

  logic                               accept;
  logic                               cen_done;
  lsps_pkg::cen_res_t                 cen_res;
  logic                               mul_start;
  logic [lsps_pkg::GainW-1:0]         mul_gain;
  logic signed [7:0]                  mul_mplier;
  logic                               mul_done;
  logic signed [lsps_pkg::ProdW-1:0]  mul_prod;

  logic [lsps_pkg::DevW-1:0]          cen_mag;
  logic signed [7:0]                  diff;
  logic [lsps_pkg::ProdW-1:0]         out_mag;
  logic [lsps_pkg::LimW-1:0]          whole;

  assign accept = s_axis_tvalid && s_axis_tready;

  lsps_centroid u_centroid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .sensors_i  (s_axis_tdata),
    .prev_dev_i (prev_q),
    .done_o     (cen_done),
    .res_o      (cen_res)
  );

  lsps_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .gain_i   (mul_gain),
    .mplier_i (mul_mplier),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= 16'd179;
      ki_q   <= 16'd0;
      kd_q   <= 16'd51;
      ilim_q <= 7'd30;
      olim_q <= 7'd10;
      md_q   <= 7'd3;
      db_q   <= 6'd1;
    end else if (cfg_we_i) begin
      case (lsps_pkg::cfg_reg_e'(cfg_idx_i))
        lsps_pkg::REG_KP:        kp_q   <= cfg_wdata_i;
        lsps_pkg::REG_KI:        ki_q   <= cfg_wdata_i;
        lsps_pkg::REG_KD:        kd_q   <= cfg_wdata_i;
        lsps_pkg::REG_ILIM:      ilim_q <= cfg_wdata_i[lsps_pkg::LimW-1:0];
        lsps_pkg::REG_OLIM:      olim_q <= cfg_wdata_i[lsps_pkg::LimW-1:0];
        lsps_pkg::REG_MIN_DRIVE: md_q   <= cfg_wdata_i[lsps_pkg::LimW-1:0];
        lsps_pkg::REG_DEADBAND:  db_q   <= cfg_wdata_i[lsps_pkg::DbW-1:0];
        default: ;
      endcase
    end
  end

  // Hold control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsps_pkg::ST_IDLE;
      prev_q      <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      integ_q     <= integ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold working and output payload
  always_ff @(posedge clk_i) begin
    dev_q      <= dev_d;
    lost_q     <= lost_d;
    in_band_q  <= in_band_d;
    sum_q      <= sum_d;
    steer_q    <= steer_d;
    out_dev_q  <= out_dev_d;
    out_lost_q <= out_lost_d;
  end

  // Sequence the PID terms through the shared multiplier
  always_comb begin
    state_d     = state_q;
    dev_d       = dev_q;
    lost_d      = lost_q;
    in_band_d   = in_band_q;
    prev_d      = prev_q;
    integ_d     = integ_q;
    sum_d       = sum_q;
    steer_d     = steer_q;
    out_dev_d   = out_dev_q;
    out_lost_d  = out_lost_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    mul_start   = 1'b0;
    mul_gain    = ki_q;
    mul_mplier  = 8'(dev_q);

    cen_mag = cen_res.dev[lsps_pkg::DevW-1] ? 7'(-cen_res.dev) : 7'(cen_res.dev);
    diff    = 8'(dev_q) - 8'(prev_q);
    out_mag = sum_q[lsps_pkg::ProdW-1] ? 24'(-sum_q) : 24'(sum_q);
    whole   = out_mag[14:8];
    if (whole != '0 && whole < md_q) begin
      whole = md_q;
    end

    s_axis_tready = (state_q == lsps_pkg::ST_IDLE);

    case (state_q)
      lsps_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lsps_pkg::ST_CENTROID;
        end
      end
      lsps_pkg::ST_CENTROID: begin
        if (cen_done) begin
          dev_d      = cen_res.dev;
          lost_d     = cen_res.lost;
          in_band_d  = (cen_mag <= {1'b0, db_q});
          mul_start  = 1'b1;
          mul_gain   = ki_q;
          mul_mplier = 8'(cen_res.dev);
          state_d    = lsps_pkg::ST_MUL_I;
        end
      end
      lsps_pkg::ST_MUL_I: begin
        if (mul_done) begin
          // clear the integral inside the deadband
          sum_d   = in_band_q ? '0 : 24'(integ_q) + mul_prod;
          state_d = lsps_pkg::ST_INT_CLAMP;
        end
      end
      lsps_pkg::ST_INT_CLAMP: begin
        integ_d    = 16'(lsps_pkg::clamp_sym(sum_q, ilim_q));
        mul_start  = 1'b1;
        mul_gain   = kp_q;
        mul_mplier = 8'(dev_q);
        state_d    = lsps_pkg::ST_MUL_P;
      end
      lsps_pkg::ST_MUL_P: begin
        if (mul_done) begin
          sum_d      = 24'(integ_q) + mul_prod;
          mul_start  = 1'b1;
          mul_gain   = kd_q;
          mul_mplier = diff;
          state_d    = lsps_pkg::ST_MUL_D;
        end
      end
      lsps_pkg::ST_MUL_D: begin
        if (mul_done) begin
          sum_d   = sum_q + mul_prod;
          prev_d  = dev_q;
          state_d = lsps_pkg::ST_OUT_CLAMP;
        end
      end
      lsps_pkg::ST_OUT_CLAMP: begin
        sum_d   = lsps_pkg::clamp_sym(sum_q, olim_q);
        state_d = lsps_pkg::ST_FINISH;
      end
      lsps_pkg::ST_FINISH: begin
        // load the output register once it is free
        if (!out_valid_q || m_axis_tready) begin
          steer_d     = sum_q[lsps_pkg::ProdW-1] ? 8'(-{1'b0, whole}) : 8'({1'b0, whole});
          out_dev_d   = dev_q;
          out_lost_d  = lost_q;
          out_valid_d = 1'b1;
          state_d     = lsps_pkg::ST_IDLE;
        end
      end
      default: state_d = lsps_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_dev_q, steer_q};
  assign m_axis_tuser  = out_lost_q;

endmodule

### tb/sv/line_sensor_pid_steering_top_test.sv
// Self-checking testbench of the line sensor steering block with its own PID predictor.
`timescale 1ns / 100ps

module line_sensor_pid_steering_top_test;

  // One steering word as the block should return it
  typedef struct packed {
    logic signed [lsps_pkg::SteerW-1:0] steer;
    logic signed [lsps_pkg::DevW-1:0]   dev;
    logic                               lost;
  } steer_word_t;

  // Predict steering words from accepted sensor words and check returned ones
  class steer_scoreboard;
    int errors;
    int kp_gain, ki_gain, kd_gain;
    int int_lim, out_lim, min_drv, dband;
    int last_dev;
    int integ_q8;
    steer_word_t steer_fifo[$];

    function new();
      errors   = 0;
      kp_gain  = 179;
      ki_gain  = 0;
      kd_gain  = 51;
      int_lim  = 30;
      out_lim  = 10;
      min_drv  = 3;
      dband    = 1;
      last_dev = 0;
      integ_q8 = 0;
    endfunction

    // Keep only the bits each register holds
    function void set_reg(lsps_pkg::cfg_reg_e idx, logic [lsps_pkg::CfgDataW-1:0] v);
      case (idx)
        lsps_pkg::REG_KP:        kp_gain = v;
        lsps_pkg::REG_KI:        ki_gain = v;
        lsps_pkg::REG_KD:        kd_gain = v;
        lsps_pkg::REG_ILIM:      int_lim = v[lsps_pkg::LimW-1:0];
        lsps_pkg::REG_OLIM:      out_lim = v[lsps_pkg::LimW-1:0];
        lsps_pkg::REG_MIN_DRIVE: min_drv = v[lsps_pkg::LimW-1:0];
        lsps_pkg::REG_DEADBAND:  dband   = v[lsps_pkg::DbW-1:0];
        default: ;
      endcase
    endfunction

    function int saturate(int v, int lim);
      if (v > lim * 256) return lim * 256;
      if (v < -lim * 256) return -lim * 256;
      return v;
    endfunction

    // Run one control step on an accepted sensor word
    function void note_sensor(logic [lsps_pkg::SensW-1:0] s);
      int sum, cnt, dev, mag, total, whole;
      bit lost;
      steer_word_t w;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < lsps_pkg::SensW; i++) begin
        if (s[i]) begin
          sum += 10 * i - 35;
          cnt++;
        end
      end
      lost = (cnt == 0 || cnt == lsps_pkg::SensW);
      dev  = lost ? last_dev : sum / cnt;
      mag  = dev < 0 ? -dev : dev;
      // clear inside the deadband, else accumulate and saturate
      if (mag <= dband) begin
        integ_q8 = 0;
      end else begin
        integ_q8 = saturate(integ_q8 + ki_gain * dev, int_lim);
      end
      total    = kp_gain * dev + integ_q8 + kd_gain * (dev - last_dev);
      last_dev = dev;
      whole    = saturate(total, out_lim) / 256;
      if (whole > 0 && whole < min_drv) whole = min_drv;
      if (whole < 0 && whole > -min_drv) whole = -min_drv;
      w.steer = whole[lsps_pkg::SteerW-1:0];
      w.dev   = dev[lsps_pkg::DevW-1:0];
      w.lost  = lost;
      steer_fifo.push_back(w);
    endfunction

    function int pending();
      return steer_fifo.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare a returned word with the oldest prediction
    task check_steer(logic [15:0] data, logic user);
      steer_word_t want;
      if (steer_fifo.size() == 0) begin
        report($sformatf("steering word %h with no sensor word pending", data));
        return;
      end
      want = steer_fifo.pop_front();
      if (data[7:0] !== want.steer)
        report($sformatf("steer %0d, want %0d", $signed(data[7:0]), want.steer));
      if (data[14:8] !== want.dev)
        report($sformatf("deviation %0d, want %0d", $signed(data[14:8]), want.dev));
      if (user !== want.lost)
        report($sformatf("line_lost %b, want %b", user, want.lost));
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          cfg_we_i      = 1'b0;
  logic [lsps_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [lsps_pkg::CfgDataW-1:0] cfg_wdata_i   = '0;

  steer_scoreboard sb = new();
  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  int sink_hold = 0;

  line_sensor_pid_steering_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop if the block hangs
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sink: check accepted words, then pick tready for the next edge
  initial begin : steer_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_steer(m_axis_tdata, m_axis_tuser);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one sensor word; drop tvalid after the final word or for an idle burst
  task automatic send_sensor(input logic [7:0] s, input bit final_word);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sensor(s);
    if (final_word) begin
      s_axis_tvalid <= 1'b0;
    end else if (src_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Mostly a narrow line under one to three sensors, some noise and lost line
  function automatic logic [7:0] line_pattern();
    int kind, width, pos;
    logic [7:0] run;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      width = $urandom_range(1, 3);
      pos   = $urandom_range(0, 8 - width);
      run   = ((8'd1 << width) - 8'd1) << pos;
      return run;
    end
    if (kind <= 7) return 8'($urandom_range(0, 255));
    if (kind == 8) return 8'h00;
    return 8'hFF;
  endfunction

  task automatic run_sensors(input int n);
    for (int i = 0; i < n; i++) send_sensor(line_pattern(), i == n - 1);
  endtask

  // Wait until every steering word is back, then let the block settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write all registers back to back, tvalid-style: we stays high through the burst
  task automatic load_regs(input logic [15:0] kp, ki, kd, ilim, olim, mdrv, dband);
    lsps_pkg::cfg_reg_e order[7];
    logic [15:0]        vals[7];
    order = '{lsps_pkg::REG_KP, lsps_pkg::REG_KI, lsps_pkg::REG_KD, lsps_pkg::REG_ILIM,
              lsps_pkg::REG_OLIM, lsps_pkg::REG_MIN_DRIVE, lsps_pkg::REG_DEADBAND};
    vals  = '{kp, ki, kd, ilim, olim, mdrv, dband};
    drain();
    for (int r = 0; r < 7; r++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= order[r];
      cfg_wdata_i <= vals[r];
      @(posedge clk_i);
      sb.set_reg(order[r], vals[r]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] directed[$];
    directed = '{8'h00, 8'h01, 8'h80, 8'hFF, 8'h18, 8'h03, 8'h07, 8'h0F, 8'hF0,
                 8'h81, 8'h02, 8'h40, 8'h11, 8'h0B, 8'hD0, 8'h00, 8'h7F, 8'hFE,
                 8'hFF, 8'h10, 8'h08, 8'h55, 8'hAA, 8'h00};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: extremes, lost line, truncation toward zero
    foreach (directed[i]) send_sensor(directed[i], i == directed.size() - 1);

    // Every register at its top value, deadband zero
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd127, 16'd127, 16'd127, 16'd0);
    run_sensors(80);

    // Every register zero: steer pinned to zero
    load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_sensors(60);

    // Build up a large integral, then lower its limit with the integral kept
    load_regs(16'd128, 16'd2000, 16'd300, 16'd127, 16'd127, 16'd5, 16'd3);
    run_sensors(80);
    load_regs(16'd128, 16'd2000, 16'd300, 16'd4, 16'd127, 16'd5, 16'd3);
    run_sensors(60);

    // Minimum drive above the output limit
    load_regs(16'd700, 16'd100, 16'd50, 16'd20, 16'd2, 16'd20, 16'd10);
    run_sensors(60);

    // Deadband beyond the widest deviation
    load_regs(16'd400, 16'd5000, 16'd80, 16'd60, 16'd100, 16'd1, 16'd63);
    run_sensors(60);

    // Back pressure: hold the sink long while words keep coming
    load_regs(16'd900, 16'd300, 16'd200, 16'd50, 16'd90, 16'd4, 16'd5);
    src_idle  = 1'b0;
    sink_hold = 300;
    run_sensors(30);
    src_idle = 1'b1;

    // Random register words, upper bits included
    for (int p = 0; p < 6; p++) begin
      load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      run_sensors(60);
    end

    // Closing stretch at full rate
    load_regs(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 500)),
              16'($urandom_range(0, 1000)), 16'd40, 16'd60, 16'd2, 16'd2);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_sensors(80);

    drain();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
